@@ rtl/ipat_pkg.sv @@
// ----------------------------------------------------------------------------
// ipat_pkg
// Shared types, character codes and helper functions of the address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipat_pkg;

    localparam int ADDR_BYTES = 16;
    localparam int DOT_OCTETS = 4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [11:0] OCTET_MAX = 12'd255;
    localparam logic [16:0] GROUP_MAX = 17'h0ffff;

    // address family codes (anything above FAM_IPV6 is unsupported)
    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    typedef enum logic [1:0] {
        PH_FIRST      = 2'd0,
        PH_LEAD_COLON = 2'd1,
        PH_RUN        = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MALFORMED  = 2'd1,
        ST_BAD_FAMILY = 2'd2
    } t_status;

    typedef struct packed {
        logic [DOT_OCTETS-1:0][7:0] octets;
        logic [2:0]                 count;
        logic                       saw;
        logic                       failed;
    } t_dot;

    typedef struct packed {
        logic [ADDR_BYTES-1:0][7:0] addr;
        logic [4:0]                 filled;
        logic [16:0]                group;
        logic                       saw_hex;
        logic                       gap_valid;
        logic [4:0]                 gap_pos;
        t_phase                     phase;
        logic                       pending;
        t_dot                       dot;
        logic                       in_tail;
        logic                       err;
        logic [1:0]                 fam;
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } t_result;

    localparam t_dot   DOT_RESET   = '0;
    localparam t_state STATE_RESET = '0;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // {hit, nibble} for a lower-case hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (is_digit(c)) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // one character into the dotted-quad recognizer
    function automatic t_dot dot_feed(input t_dot d, input logic [7:0] c);
        t_dot        r;
        logic [1:0]  slot;
        logic [7:0]  cur;
        logic [11:0] nv;
        logic [2:0]  cnt;
        r    = d;
        slot = d.saw ? (d.count[1:0] - 2'd1) : d.count[1:0];
        cur  = d.octets[slot];
        nv   = ({4'd0, cur} * 12'd10) + {8'd0, c[3:0]};
        cnt  = d.count + 3'd1;
        if (!d.failed) begin
            if (is_digit(c)) begin
                if (d.saw && (cur == 8'd0)) begin
                    r.failed = 1'b1;
                end else if (nv > OCTET_MAX) begin
                    r.failed = 1'b1;
                end else begin
                    r.octets[slot] = nv[7:0];
                    if (!d.saw) begin
                        r.count = cnt;
                        if (cnt > 3'(DOT_OCTETS)) begin
                            r.failed = 1'b1;
                        end else begin
                            r.saw = 1'b1;
                        end
                    end
                end
            end else if ((c == CH_DOT) && d.saw) begin
                if (d.count >= 3'(DOT_OCTETS)) begin
                    r.failed = 1'b1;
                end else begin
                    r.octets[d.count[1:0]] = 8'd0;
                    r.saw = 1'b0;
                end
            end else begin
                r.failed = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipat_in_if.sv @@
// ----------------------------------------------------------------------------
// ipat_in_if
// Character request channel: one text character and the address family.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic [1:0] family;

    modport source (output valid, output ch, output family, input ready);
    modport sink   (input valid, input ch, input family, output ready);
endinterface

`default_nettype wire

@@ rtl/ipat_out_if.sv @@
// ----------------------------------------------------------------------------
// ipat_out_if
// Result request channel: parse status and the 128-bit address.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] address_high;
    logic [63:0] address_low;

    modport source (output valid, output status, output address_high, output address_low,
                    input ready);
    modport sink   (input valid, input status, input address_high, input address_low,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/ipat_char_step.sv @@
// ----------------------------------------------------------------------------
// ipat_char_step
// Next parse state for one non-terminating character.
// ----------------------------------------------------------------------------
`default_nettype none

module ipat_char_step
    import ipat_pkg::*;
(
    input  var t_state     i_st,
    input  var logic [7:0] i_ch,
    input  var logic [1:0] i_family,
    output var t_state     o_st
);

    function automatic t_state v6_feed(input t_state s, input logic [7:0] c);
        t_state      r;
        logic [7:0]  lc;
        logic [4:0]  hv;
        logic [16:0] gv;
        logic [5:0]  fill6;
        r     = s;
        lc    = ((c >= CH_UA) && (c <= CH_UZ)) ? (c + CASE_BIT) : c;
        hv    = hex_decode(lc);
        gv    = {s.group[12:0], hv[3:0]};
        fill6 = {1'b0, s.filled};
        r.pending = 1'b0;
        if (s.in_tail) begin
            r.dot = dot_feed(s.dot, c);
        end else if (hv[4]) begin
            r.group = gv;
            if (gv > GROUP_MAX) begin
                r.err = 1'b1;
            end else begin
                r.saw_hex = 1'b1;
                r.dot     = dot_feed(s.dot, lc);
            end
        end else if (lc == CH_COLON) begin
            r.dot = DOT_RESET;
            if (!s.saw_hex) begin
                if (s.gap_valid) begin
                    r.err = 1'b1;
                end else begin
                    r.gap_valid = 1'b1;
                    r.gap_pos   = s.filled;
                end
            end else begin
                r.pending = 1'b1;
                if ((fill6 + 6'd2) > 6'(ADDR_BYTES)) begin
                    r.err = 1'b1;
                end else begin
                    r.addr[s.filled[3:0]]        = s.group[15:8];
                    r.addr[s.filled[3:0] + 4'd1] = s.group[7:0];
                    r.filled  = s.filled + 5'd2;
                    r.saw_hex = 1'b0;
                    r.group   = '0;
                end
            end
        end else if (lc == CH_DOT) begin
            if ((fill6 + 6'd4) > 6'(ADDR_BYTES)) begin
                r.err = 1'b1;
            end else begin
                r.dot     = dot_feed(s.dot, lc);
                r.in_tail = 1'b1;
            end
        end else begin
            r.err = 1'b1;
        end
        return r;
    endfunction

    logic [1:0] w_fam;
    t_state     w_tmp;

    always_comb begin
        w_fam = (i_st.phase == PH_FIRST) ? i_family : i_st.fam;
        w_tmp = i_st;
        w_tmp.fam = w_fam;
        o_st = w_tmp;
        if ((w_fam > FAM_IPV6) || i_st.err) begin
            o_st.phase = PH_RUN;
        end else if (w_fam == FAM_IPV4) begin
            o_st.phase = PH_RUN;
            o_st.dot   = dot_feed(i_st.dot, i_ch);
            if (o_st.dot.failed) begin
                o_st.err = 1'b1;
            end
        end else if (i_st.phase == PH_FIRST) begin
            if (i_ch == CH_COLON) begin
                o_st.phase = PH_LEAD_COLON;
            end else begin
                w_tmp.phase = PH_RUN;
                o_st = v6_feed(w_tmp, i_ch);
            end
        end else if (i_st.phase == PH_LEAD_COLON) begin
            w_tmp.phase = PH_RUN;
            if (i_ch != CH_COLON) begin
                o_st = w_tmp;
                o_st.err = 1'b1;
            end else begin
                o_st = v6_feed(w_tmp, i_ch);
            end
        end else begin
            o_st = v6_feed(w_tmp, i_ch);
        end
    end

endmodule

`default_nettype wire

@@ rtl/ipat_finish.sv @@
// ----------------------------------------------------------------------------
// ipat_finish
// Result for the terminating character: last group, gap expansion, status.
// ----------------------------------------------------------------------------
`default_nettype none

module ipat_finish
    import ipat_pkg::*;
(
    input  var t_state     i_st,
    input  var logic [1:0] i_family,
    output var t_result    o_res
);

    logic [1:0]                 w_fam;
    logic                       w_ok;
    logic [5:0]                 w_fill;
    logic [5:0]                 w_gap;
    logic [5:0]                 w_src;
    logic [ADDR_BYTES-1:0][7:0] w_a;
    logic [ADDR_BYTES-1:0][7:0] w_b;

    always_comb begin
        w_fam  = (i_st.phase == PH_FIRST) ? i_family : i_st.fam;
        w_ok   = (i_st.phase == PH_RUN) && !i_st.pending && !i_st.err;
        w_fill = {1'b0, i_st.filled};
        w_gap  = {1'b0, i_st.gap_pos};
        w_a    = i_st.addr;
        w_src  = '0;

        // flush the open group or dotted tail
        if (i_st.in_tail) begin
            if (i_st.dot.failed || (i_st.dot.count < 3'(DOT_OCTETS))
                    || ((w_fill + 6'd4) > 6'(ADDR_BYTES))) begin
                w_ok = 1'b0;
            end else begin
                for (int i = 0; i < DOT_OCTETS; i++) begin
                    w_a[i_st.filled[3:0] + 4'(i)] = i_st.dot.octets[i];
                end
                w_fill = w_fill + 6'd4;
            end
        end else if (i_st.saw_hex) begin
            if ((w_fill + 6'd2) > 6'(ADDR_BYTES)) begin
                w_ok = 1'b0;
            end else begin
                w_a[i_st.filled[3:0]]        = i_st.group[15:8];
                w_a[i_st.filled[3:0] + 4'd1] = i_st.group[7:0];
                w_fill = w_fill + 6'd2;
            end
        end

        // move the bytes after the gap to the end of the address
        w_b = w_a;
        if (i_st.gap_valid) begin
            if ((w_fill >= 6'(ADDR_BYTES)) || (w_gap > w_fill)) begin
                w_ok = 1'b0;
            end else begin
                for (int k = 0; k < ADDR_BYTES; k++) begin
                    w_src = 6'(k) + w_fill - 6'(ADDR_BYTES);
                    if (6'(k) < w_gap) begin
                        w_b[k] = w_a[k];
                    end else if ((6'(k) + w_fill) >= (6'(ADDR_BYTES) + w_gap)) begin
                        w_b[k] = w_a[w_src[3:0]];
                    end else begin
                        w_b[k] = 8'd0;
                    end
                end
                w_fill = 6'(ADDR_BYTES);
            end
        end
        if (w_fill != 6'(ADDR_BYTES)) begin
            w_ok = 1'b0;
        end

        o_res.status       = ST_MALFORMED;
        o_res.address_high = '0;
        o_res.address_low  = '0;
        if (w_fam > FAM_IPV6) begin
            o_res.status = ST_BAD_FAMILY;
        end else if (w_fam == FAM_IPV4) begin
            if (!i_st.err && !i_st.dot.failed && (i_st.dot.count >= 3'(DOT_OCTETS))) begin
                o_res.status = ST_OK;
                o_res.address_low[31:0] = {i_st.dot.octets[0], i_st.dot.octets[1],
                                           i_st.dot.octets[2], i_st.dot.octets[3]};
            end
        end else if (w_ok) begin
            o_res.status = ST_OK;
            for (int k = 0; k < ADDR_BYTES / 2; k++) begin
                o_res.address_high[63 - 8 * k -: 8] = w_b[k];
                o_res.address_low[63 - 8 * k -: 8]  = w_b[k + ADDR_BYTES / 2];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/ip_address_text_parser.sv @@
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Streaming IPv4 / IPv6 address text parser, one character per request.
// ----------------------------------------------------------------------------
// The block takes an address string one character per request on i_req and
// ends it with a zero character; the family (0 IPv4, 1 IPv6, other values
// unsupported) is taken from the first character of each string only. Each
// character is captured in an input register; the next parse state is computed
// by shallow logic and written to the state register, for an ordinary character
// in the following cycle, so one character per clock is sustained while no
// terminator waits. The terminating character produces one result request on
// o_res: the result is written into the result register, which drives
// o_res.valid. The result carries status 0 with the address (IPv6 in
// address_high / address_low, big-endian; IPv4 in address_low[31:0], first
// octet highest), status 1 for malformed text or status 2 for an unsupported
// family, with a zero address on any failure. The gap expansion of "::" happens
// in the same cycle as the terminator, so strings may follow each other without
// idle cycles. Only a terminator waits when the result register still holds an
// untaken result; ordinary characters keep flowing past a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_text_parser
    import ipat_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    ipat_in_if.sink      i_req,
    ipat_out_if.source   o_res
);

    // input register
    logic       r_in_vld;
    logic       n_in_vld;
    logic [7:0] r_in_ch;
    logic [1:0] r_in_fam;

    // parse state
    t_state     r_st;
    t_state     n_st;

    // result register
    logic       r_out_vld;
    logic       n_out_vld;
    t_result    r_out;

    t_state     w_step;
    t_result    w_fin;
    logic       w_term;
    logic       w_fire;
    logic       w_in_take;

    ipat_char_step u_char_step (
        .i_st     (r_st),
        .i_ch     (r_in_ch),
        .i_family (r_in_fam),
        .o_st     (w_step)
    );

    ipat_finish u_finish (
        .i_st     (r_st),
        .i_family (r_in_fam),
        .o_res    (w_fin)
    );

    // a terminator needs a free (or draining) result register
    assign w_term    = (r_in_ch == CH_NUL);
    assign w_fire    = r_in_vld && (!w_term || !r_out_vld || o_res.ready);
    assign w_in_take = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_vld || w_fire;

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_take) begin
            n_in_vld = 1'b1;
        end else if (w_fire) begin
            n_in_vld = 1'b0;
        end

        // every string starts from the reset state
        n_st = r_st;
        if (w_fire) begin
            n_st = w_term ? STATE_RESET : w_step;
        end

        n_out_vld = r_out_vld;
        if (w_fire && w_term) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_st      <= STATE_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_st      <= n_st;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_ch  <= i_req.ch;
            r_in_fam <= i_req.family;
        end
        if (w_fire && w_term) begin
            r_out <= w_fin;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.status       = r_out.status;
    assign o_res.address_high = r_out.address_high;
    assign o_res.address_low  = r_out.address_low;

endmodule

`default_nettype wire
